@@ rtl/core/lcc_pkg.sv @@
// Shared constants for the LED comet chase stepper.
`default_nettype none
package lcc_pkg;

  // Ring size limit and field widths.
  localparam int unsigned MaxLeds   = 1024;
  localparam int unsigned IdxW      = 10;
  localparam int unsigned LenW      = 11;
  localparam int unsigned TimeW     = 32;
  localparam int unsigned ColW      = 8;
  localparam int unsigned FacW      = 9;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 32;
  localparam int unsigned CntW      = 5;

  // Full-scale Q8 factor and rounding constant.
  localparam logic [FacW-1:0] FacFull = 9'd256;
  localparam logic [15:0]     RoundQ8 = 16'd128;

  // Configuration register indices.
  localparam logic [CfgIdxW-1:0] RegHeadRed   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegHeadGreen = 3'd1;
  localparam logic [CfgIdxW-1:0] RegHeadBlue  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegNearFac   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegFarFac    = 3'd4;
  localparam logic [CfgIdxW-1:0] RegInterval  = 3'd5;
  localparam logic [CfgIdxW-1:0] RegCcw       = 3'd6;
  localparam logic [CfgIdxW-1:0] RegLength    = 3'd7;

  // Input command codes.
  localparam logic CmdBegin  = 1'b0;
  localparam logic CmdUpdate = 1'b1;

endpackage
`default_nettype wire

@@ rtl/core/led_comet_chase_stepper.sv @@
// Top level of the LED comet chase stepper: sequencer, serial divider and frame builder.
`default_nettype none
// Each input beat is a begin or update command with a millisecond time stamp; the
// block answers with at most one frame beat (head index, two tail indices and
// the scaled tail colours). A begin command, or any command on an empty strip,
// goes from the check state straight to the emit state. An update that arrives
// before one step interval has passed gives no frame. An update that steps
// passes through the divide, update and emit states: one restoring
// divide-and-compare unit produces one quotient bit a cycle, and the same pass
// folds the quotient bits into the step count modulo the ring length and reduces
// the stored head position modulo the ring length. Input is refused while a
// command is in progress; a finished frame sits in the output register and the
// block returns to accepting input as soon as that register is free.
module led_comet_chase_stepper (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // Configuration write port.
  input  wire logic                             cfg_we_i,
  input  wire logic [lcc_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  wire logic [lcc_pkg::CfgDataW-1:0]     cfg_data_i,
  // Command channel.
  input  wire logic                             in_valid_i,
  output      logic                             in_ready_o,
  input  wire logic                             command_i,
  input  wire logic [lcc_pkg::TimeW-1:0]        now_ms_i,
  // Frame channel.
  output      logic                             out_valid_o,
  input  wire logic                             out_ready_i,
  output      logic                             strip_empty_o,
  output      logic [lcc_pkg::IdxW-1:0]         head_index_o,
  output      logic [lcc_pkg::IdxW-1:0]         near_tail_index_o,
  output      logic                             near_tail_present_o,
  output      logic [lcc_pkg::IdxW-1:0]         far_tail_index_o,
  output      logic                             far_tail_present_o,
  output      logic [lcc_pkg::ColW-1:0]         near_tail_red_o,
  output      logic [lcc_pkg::ColW-1:0]         near_tail_green_o,
  output      logic [lcc_pkg::ColW-1:0]         near_tail_blue_o,
  output      logic [lcc_pkg::ColW-1:0]         far_tail_red_o,
  output      logic [lcc_pkg::ColW-1:0]         far_tail_green_o,
  output      logic [lcc_pkg::ColW-1:0]         far_tail_blue_o
);

  // Sequencer state codes.
  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StCheck = 3'd1;
  localparam logic [2:0] StDiv   = 3'd2;
  localparam logic [2:0] StUpd   = 3'd3;
  localparam logic [2:0] StEmit  = 3'd4;

  localparam int unsigned TW = lcc_pkg::TimeW;
  localparam int unsigned IW = lcc_pkg::IdxW;
  localparam int unsigned LW = lcc_pkg::LenW;
  localparam int unsigned CW = lcc_pkg::ColW;
  localparam int unsigned FW = lcc_pkg::FacW;

  // Rounded Q8 scaling of one colour component; the result never exceeds 255.
  function automatic logic [CW-1:0] scale_q8(input logic [CW-1:0] comp,
                                             input logic [FW-1:0] fac);
    logic [FW-1:0] f;
    logic [15:0]   prod;
    begin
      f    = (fac > lcc_pkg::FacFull) ? lcc_pkg::FacFull : fac;
      prod = 16'({8'd0, comp} * {7'd0, f}) + lcc_pkg::RoundQ8;
      return prod[15:8];
    end
  endfunction

  // Tail index k LEDs behind the head, wrapped round a ring of n LEDs (k < n).
  function automatic logic [IW-1:0] tail_idx(input logic [IW-1:0] pos,
                                             input logic [LW-1:0] n,
                                             input logic          ccw,
                                             input logic [1:0]    k);
    logic [LW:0] t;
    begin
      if (ccw) begin
        t = {2'd0, pos} + {10'd0, k};
      end else begin
        t = {2'd0, pos} + {1'b0, n} - {10'd0, k};
      end
      if (t >= {1'b0, n}) begin
        t = t - {1'b0, n};
      end
      return t[IW-1:0];
    end
  endfunction

  // Configuration registers.
  logic [CW-1:0] red_q, green_q, blue_q;
  logic [FW-1:0] near_fac_q, far_fac_q;
  logic [TW-1:0] interval_q;
  logic          ccw_q;
  logic [LW-1:0] len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_q      <= '0;
      green_q    <= '0;
      blue_q     <= '0;
      near_fac_q <= 9'd128;
      far_fac_q  <= 9'd64;
      interval_q <= 32'd1;
      ccw_q      <= 1'b0;
      len_q      <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lcc_pkg::RegHeadRed:   red_q      <= cfg_data_i[CW-1:0];
        lcc_pkg::RegHeadGreen: green_q    <= cfg_data_i[CW-1:0];
        lcc_pkg::RegHeadBlue:  blue_q     <= cfg_data_i[CW-1:0];
        lcc_pkg::RegNearFac:   near_fac_q <= cfg_data_i[FW-1:0];
        lcc_pkg::RegFarFac:    far_fac_q  <= cfg_data_i[FW-1:0];
        lcc_pkg::RegInterval:  interval_q <= cfg_data_i[TW-1:0];
        lcc_pkg::RegCcw:       ccw_q      <= cfg_data_i[0];
        lcc_pkg::RegLength:    len_q      <= cfg_data_i[LW-1:0];
      endcase
    end
  end

  // Effective LED count and step interval.
  logic [LW-1:0] n_leds;
  logic [TW-1:0] ivl;
  assign n_leds = (len_q > LW'(lcc_pkg::MaxLeds)) ? LW'(lcc_pkg::MaxLeds) : len_q;
  assign ivl    = (interval_q == '0) ? TW'(1) : interval_q;

  // Control and working registers.
  logic [2:0]              state_q, state_d;
  logic [lcc_pkg::CntW-1:0] cnt_q, cnt_d;
  logic [IW-1:0]           head_q, head_d;
  logic [TW-1:0]           last_q, last_d;
  logic                    out_valid_q, out_valid_d;
  logic                    cmd_q;
  logic [TW-1:0]           now_q;
  logic [TW-1:0]           rem_q, rem_d;
  logic [TW-1:0]           dvd_q, dvd_d;
  logic [IW-1:0]           smod_q, smod_d;
  logic [IW-1:0]           hmod_q, hmod_d;
  logic [IW-1:0]           hsh_q, hsh_d;
  logic                    load_out;

  logic in_acc;
  assign in_ready_o = (state_q == StIdle);
  assign in_acc     = in_valid_i && in_ready_o;

  // One step of the shared unit: quotient bit, and both modular reductions.
  logic [TW:0]   r_shift, r_sub;
  logic          q_bit;
  logic [LW-1:0] s_shift, h_shift;
  logic [IW-1:0] s_next, h_next;
  logic [TW-1:0] elapsed;

  assign elapsed = now_q - last_q;
  assign r_shift = {rem_q, dvd_q[TW-1]};
  assign r_sub   = r_shift - {1'b0, ivl};
  assign q_bit   = (r_shift >= {1'b0, ivl});
  assign s_shift = {smod_q, q_bit};
  assign s_next  = (s_shift >= n_leds) ? IW'(s_shift - n_leds) : s_shift[IW-1:0];
  assign h_shift = {hmod_q, hsh_q[IW-1]};
  assign h_next  = (h_shift >= n_leds) ? IW'(h_shift - n_leds) : h_shift[IW-1:0];

  // New head position from the reduced head and step count.
  logic [LW:0]   new_pos;
  logic [LW:0]   new_pos_w;
  always_comb begin
    if (ccw_q) begin
      new_pos = {2'd0, hmod_q} + {1'b0, n_leds} - {2'd0, smod_q};
    end else begin
      new_pos = {2'd0, hmod_q} + {2'd0, smod_q};
    end
    new_pos_w = (new_pos >= {1'b0, n_leds}) ? (new_pos - {1'b0, n_leds}) : new_pos;
  end

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    head_d      = head_q;
    last_d      = last_q;
    rem_d       = rem_q;
    dvd_d       = dvd_q;
    smod_d      = smod_q;
    hmod_d      = hmod_q;
    hsh_d       = hsh_q;
    out_valid_d = out_valid_q;
    load_out    = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          state_d = StCheck;
        end
      end
      StCheck: begin
        if (cmd_q == lcc_pkg::CmdBegin) begin
          head_d  = '0;
          last_d  = now_q;
          state_d = StEmit;
        end else if (n_leds == '0) begin
          last_d  = now_q;
          state_d = StEmit;
        end else if (elapsed < ivl) begin
          state_d = StIdle;
        end else begin
          rem_d   = '0;
          dvd_d   = elapsed;
          smod_d  = '0;
          hmod_d  = '0;
          hsh_d   = head_q;
          cnt_d   = '1;
          state_d = StDiv;
        end
      end
      StDiv: begin
        rem_d  = q_bit ? r_sub[TW-1:0] : r_shift[TW-1:0];
        dvd_d  = {dvd_q[TW-2:0], 1'b0};
        smod_d = s_next;
        if (cnt_q < lcc_pkg::CntW'(IW)) begin
          hmod_d = h_next;
          hsh_d  = {hsh_q[IW-2:0], 1'b0};
        end
        cnt_d = cnt_q - lcc_pkg::CntW'(1);
        if (cnt_q == '0) begin
          state_d = StUpd;
        end
      end
      StUpd: begin
        // Stored time moves on by whole intervals: now minus the remainder.
        last_d  = now_q - rem_q;
        head_d  = new_pos_w[IW-1:0];
        state_d = StEmit;
      end
      StEmit: begin
        if (!out_valid_q || out_ready_i) begin
          load_out    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      head_q      <= '0;
      last_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      head_q      <= head_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers need no reset.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q <= command_i;
      now_q <= now_ms_i;
    end
    rem_q  <= rem_d;
    dvd_q  <= dvd_d;
    smod_q <= smod_d;
    hmod_q <= hmod_d;
    hsh_q  <= hsh_d;
  end

  // Frame assembly into the output register.
  logic has_near, has_far, is_empty;
  assign is_empty = (n_leds == '0);
  assign has_near = (n_leds > LW'(1));
  assign has_far  = (n_leds > LW'(2));

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      strip_empty_o       <= is_empty;
      head_index_o        <= is_empty ? '0 : head_q;
      near_tail_present_o <= has_near;
      far_tail_present_o  <= has_far;
      near_tail_index_o   <= has_near ? tail_idx(head_q, n_leds, ccw_q, 2'd1) : '0;
      far_tail_index_o    <= has_far  ? tail_idx(head_q, n_leds, ccw_q, 2'd2) : '0;
      near_tail_red_o     <= has_near ? scale_q8(red_q,   near_fac_q) : '0;
      near_tail_green_o   <= has_near ? scale_q8(green_q, near_fac_q) : '0;
      near_tail_blue_o    <= has_near ? scale_q8(blue_q,  near_fac_q) : '0;
      far_tail_red_o      <= has_far  ? scale_q8(red_q,   far_fac_q)  : '0;
      far_tail_green_o    <= has_far  ? scale_q8(green_q, far_fac_q)  : '0;
      far_tail_blue_o     <= has_far  ? scale_q8(blue_q,  far_fac_q)  : '0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

@@ tb/tb.sv @@
// Self-checking testbench for the LED comet chase stepper.
module tb;

  localparam int unsigned CycleLimit   = 1000000;
  localparam int unsigned SettleCycles = 50;
  localparam int unsigned LongStall    = 600;
  localparam int unsigned PhaseItems   = 135;

  typedef struct packed {
    logic                      cmd;
    logic [lcc_pkg::TimeW-1:0] now;
  } chase_cmd_t;

  typedef struct packed {
    logic                     empty;
    logic [lcc_pkg::IdxW-1:0] head;
    logic [lcc_pkg::IdxW-1:0] near_idx;
    logic                     near_on;
    logic [lcc_pkg::IdxW-1:0] far_idx;
    logic                     far_on;
    logic [lcc_pkg::ColW-1:0] near_r;
    logic [lcc_pkg::ColW-1:0] near_g;
    logic [lcc_pkg::ColW-1:0] near_b;
    logic [lcc_pkg::ColW-1:0] far_r;
    logic [lcc_pkg::ColW-1:0] far_g;
    logic [lcc_pkg::ColW-1:0] far_b;
  } frame_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                         cfg_we = 1'b0;
  logic [lcc_pkg::CfgIdxW-1:0]  cfg_idx = '0;
  logic [lcc_pkg::CfgDataW-1:0] cfg_data = '0;

  logic       in_valid = 1'b0;
  logic       in_ready;
  chase_cmd_t offered = '0;
  chase_cmd_t next_cmd;

  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic                     strip_empty;
  logic [lcc_pkg::IdxW-1:0] head_index, near_tail_index, far_tail_index;
  logic                     near_tail_present, far_tail_present;
  logic [lcc_pkg::ColW-1:0] near_tail_red, near_tail_green, near_tail_blue;
  logic [lcc_pkg::ColW-1:0] far_tail_red, far_tail_green, far_tail_blue;

  // Register copies, at their reset values.
  logic [lcc_pkg::ColW-1:0]  sh_red = '0, sh_green = '0, sh_blue = '0;
  logic [lcc_pkg::FacW-1:0]  sh_near = 9'd128, sh_far = 9'd64;
  logic [lcc_pkg::TimeW-1:0] sh_ival = 32'd1;
  logic                      sh_ccw = 1'b0;
  logic [lcc_pkg::LenW-1:0]  sh_len = '0;

  // Predicted comet state.
  logic [lcc_pkg::IdxW-1:0]  head_pos = '0;
  logic [lcc_pkg::TimeW-1:0] last_step = '0;

  // Time base the stimulus builds on, tracking the stored step time.
  logic [lcc_pkg::TimeW-1:0] gen_last = '0;

  chase_cmd_t pending[$];
  frame_t     frames_due[$];

  int unsigned sender_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic        hold_sender = 1'b0;
  int unsigned stalls_asked = 0;
  int unsigned stalls_granted = 0;
  int unsigned stall_left = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  led_comet_chase_stepper DUT (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .cfg_we_i           (cfg_we),
    .cfg_idx_i          (cfg_idx),
    .cfg_data_i         (cfg_data),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready),
    .command_i          (offered.cmd),
    .now_ms_i           (offered.now),
    .out_valid_o        (out_valid),
    .out_ready_i        (out_ready),
    .strip_empty_o      (strip_empty),
    .head_index_o       (head_index),
    .near_tail_index_o  (near_tail_index),
    .near_tail_present_o(near_tail_present),
    .far_tail_index_o   (far_tail_index),
    .far_tail_present_o (far_tail_present),
    .near_tail_red_o    (near_tail_red),
    .near_tail_green_o  (near_tail_green),
    .near_tail_blue_o   (near_tail_blue),
    .far_tail_red_o     (far_tail_red),
    .far_tail_green_o   (far_tail_green),
    .far_tail_blue_o    (far_tail_blue)
  );

  // Clock with a period of 10.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Number of LEDs in the ring, saturated at the largest ring.
  function automatic int unsigned ring_leds();
    return (sh_len > lcc_pkg::MaxLeds) ? lcc_pkg::MaxLeds : int'(sh_len);
  endfunction

  // Head colour component scaled by a clamped Q8 factor, rounded.
  function automatic logic [lcc_pkg::ColW-1:0] tail_shade(logic [lcc_pkg::ColW-1:0] c,
                                                          logic [lcc_pkg::FacW-1:0] fac);
    int unsigned f;
    f = (fac > lcc_pkg::FacFull) ? lcc_pkg::FacFull : fac;
    return lcc_pkg::ColW'((c * f + lcc_pkg::RoundQ8) >> 8);
  endfunction

  // Frame for the current head position and register settings.
  function automatic frame_t comet_frame();
    frame_t      f;
    int unsigned n, pos;
    f = '0;
    n = ring_leds();
    if (n == 0) begin
      f.empty = 1'b1;
      return f;
    end
    pos = head_pos % n;
    f.head = lcc_pkg::IdxW'(pos);
    if (n > 1) begin
      f.near_idx = lcc_pkg::IdxW'(sh_ccw ? (pos + 1) % n : (pos + n - 1) % n);
      f.near_on  = 1'b1;
      f.near_r   = tail_shade(sh_red, sh_near);
      f.near_g   = tail_shade(sh_green, sh_near);
      f.near_b   = tail_shade(sh_blue, sh_near);
    end
    if (n > 2) begin
      f.far_idx = lcc_pkg::IdxW'(sh_ccw ? (pos + 2) % n : (pos + n - 2) % n);
      f.far_on  = 1'b1;
      f.far_r   = tail_shade(sh_red, sh_far);
      f.far_g   = tail_shade(sh_green, sh_far);
      f.far_b   = tail_shade(sh_blue, sh_far);
    end
    return f;
  endfunction

  // Advances the predicted comet for one accepted command and queues its frame, if any.
  function automatic void take_command(chase_cmd_t c);
    int unsigned n, iv, elapsed, steps, s, pos;
    n = ring_leds();
    if (c.cmd == lcc_pkg::CmdBegin) begin
      head_pos  = '0;
      last_step = c.now;
      frames_due.push_back(comet_frame());
    end else if (n == 0) begin
      last_step = c.now;
      frames_due.push_back(comet_frame());
    end else begin
      iv      = (sh_ival == 0) ? 1 : sh_ival;
      elapsed = c.now - last_step;
      if (elapsed >= iv) begin
        steps     = elapsed / iv;
        last_step = last_step + steps * iv;
        s         = steps % n;
        pos       = head_pos % n;
        head_pos  = lcc_pkg::IdxW'(sh_ccw ? (pos + n - s) % n : (pos + s) % n);
        frames_due.push_back(comet_frame());
      end
    end
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatches++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endfunction

  // Command driver: offers the next pending command when the slot is free, unless held or idling at random.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready)
        take_command(offered);
      if (!in_valid || in_ready) begin
        if (pending.size() != 0 && !hold_sender && $urandom_range(99) >= sender_idle_pct) begin
          next_cmd = pending.pop_front();
          offered  <= next_cmd;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Frame monitor: every accepted beat is checked against the oldest prediction.
  always @(posedge clk) begin
    frame_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (frames_due.size() == 0) begin
          mismatches++;
          $error("frame beat arrived with no frame expected");
        end else begin
          want = frames_due.pop_front();
          check_field("strip_empty", want.empty, strip_empty);
          check_field("head_index", want.head, head_index);
          check_field("near_tail_index", want.near_idx, near_tail_index);
          check_field("near_tail_present", want.near_on, near_tail_present);
          check_field("far_tail_index", want.far_idx, far_tail_index);
          check_field("far_tail_present", want.far_on, far_tail_present);
          check_field("near_tail_red", want.near_r, near_tail_red);
          check_field("near_tail_green", want.near_g, near_tail_green);
          check_field("near_tail_blue", want.near_b, near_tail_blue);
          check_field("far_tail_red", want.far_r, far_tail_red);
          check_field("far_tail_green", want.far_g, far_tail_green);
          check_field("far_tail_blue", want.far_b, far_tail_blue);
        end
      end
      out_ready <= (stall_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Long receiver hold-off, counted here so the block backs up onto its input.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (stalls_granted < stalls_asked) begin
      stall_left     <= LongStall;
      stalls_granted <= stalls_granted + 1;
    end
  end

  // Guard against a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Queues one command and keeps the stimulus time base in step with it.
  task automatic push_command(logic cmd, logic [lcc_pkg::TimeW-1:0] now);
    int unsigned iv, gap;
    chase_cmd_t  c;
    iv  = (sh_ival == 0) ? 1 : sh_ival;
    gap = now - gen_last;
    if (cmd == lcc_pkg::CmdBegin || ring_leds() == 0)
      gen_last = now;
    else if (gap >= iv)
      gen_last = gen_last + (gap / iv) * iv;
    c.cmd = cmd;
    c.now = now;
    pending.push_back(c);
  endtask

  task automatic set_reg(logic [lcc_pkg::CfgIdxW-1:0] idx, logic [lcc_pkg::CfgDataW-1:0] val);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    case (idx)
      lcc_pkg::RegHeadRed:   sh_red = val[lcc_pkg::ColW-1:0];
      lcc_pkg::RegHeadGreen: sh_green = val[lcc_pkg::ColW-1:0];
      lcc_pkg::RegHeadBlue:  sh_blue = val[lcc_pkg::ColW-1:0];
      lcc_pkg::RegNearFac:   sh_near = val[lcc_pkg::FacW-1:0];
      lcc_pkg::RegFarFac:    sh_far = val[lcc_pkg::FacW-1:0];
      lcc_pkg::RegInterval:  sh_ival = val[lcc_pkg::TimeW-1:0];
      lcc_pkg::RegCcw:       sh_ccw = val[0];
      lcc_pkg::RegLength:    sh_len = val[lcc_pkg::LenW-1:0];
      default:               ;
    endcase
  endtask

  task automatic set_all(logic [lcc_pkg::ColW-1:0] r, logic [lcc_pkg::ColW-1:0] g,
                         logic [lcc_pkg::ColW-1:0] b,
                         logic [lcc_pkg::FacW-1:0] nf, logic [lcc_pkg::FacW-1:0] ff,
                         logic [lcc_pkg::TimeW-1:0] iv,
                         logic ccw, logic [lcc_pkg::LenW-1:0] len);
    set_reg(lcc_pkg::RegHeadRed, lcc_pkg::CfgDataW'(r));
    set_reg(lcc_pkg::RegHeadGreen, lcc_pkg::CfgDataW'(g));
    set_reg(lcc_pkg::RegHeadBlue, lcc_pkg::CfgDataW'(b));
    set_reg(lcc_pkg::RegNearFac, lcc_pkg::CfgDataW'(nf));
    set_reg(lcc_pkg::RegFarFac, lcc_pkg::CfgDataW'(ff));
    set_reg(lcc_pkg::RegInterval, lcc_pkg::CfgDataW'(iv));
    set_reg(lcc_pkg::RegCcw, lcc_pkg::CfgDataW'(ccw));
    set_reg(lcc_pkg::RegLength, lcc_pkg::CfgDataW'(len));
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Waits until every command is taken and every frame is back, then lets a
  // late step finish inside the block.
  task automatic settle();
    while (pending.size() != 0 || in_valid || frames_due.size() != 0)
      @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Random settings, biased towards the extremes.
  task automatic random_setup();
    logic [lcc_pkg::ColW-1:0]  col[3];
    logic [lcc_pkg::FacW-1:0]  fac[2];
    logic [lcc_pkg::TimeW-1:0] iv;
    logic [lcc_pkg::LenW-1:0]  len;
    int unsigned               pick;
    foreach (col[i]) begin
      pick   = $urandom_range(99);
      col[i] = (pick < 15) ? 8'd0 : (pick < 30) ? 8'd255 : lcc_pkg::ColW'($urandom);
    end
    foreach (fac[i]) begin
      pick   = $urandom_range(99);
      fac[i] = (pick < 15) ? lcc_pkg::FacFull :
               (pick < 25) ? 9'd0 : lcc_pkg::FacW'($urandom_range(511));
    end
    pick = $urandom_range(99);
    if (pick < 10)      iv = '0;
    else if (pick < 25) iv = 32'd1;
    else if (pick < 70) iv = $urandom_range(20, 2);
    else if (pick < 92) iv = $urandom_range(100000, 21);
    else                iv = 32'hFFFF_FFFF - $urandom_range(3);
    pick = $urandom_range(99);
    if (pick < 6)       len = '0;
    else if (pick < 14) len = lcc_pkg::LenW'($urandom_range(3, 1));
    else if (pick < 80) len = lcc_pkg::LenW'($urandom_range(64, 4));
    else if (pick < 92) len = lcc_pkg::LenW'($urandom_range(lcc_pkg::MaxLeds, 65));
    else                len = lcc_pkg::LenW'($urandom_range(2047, lcc_pkg::MaxLeds));
    set_all(col[0], col[1], col[2], fac[0], fac[1], iv, 1'($urandom), len);
  endtask

  // Mostly well-formed runs of updates after a begin, with some early ticks,
  // restarts and raw random time stamps mixed in.
  task automatic queue_commands(int unsigned count);
    int unsigned               iv, pick, k;
    logic [lcc_pkg::TimeW-1:0] delta;
    iv = (sh_ival == 0) ? 1 : sh_ival;
    push_command(lcc_pkg::CmdBegin, $urandom);
    repeat (count - 1) begin
      pick = $urandom_range(99);
      if (pick < 7) begin
        push_command(lcc_pkg::CmdBegin, $urandom);
      end else if (pick < 13) begin
        push_command(lcc_pkg::CmdUpdate, $urandom);
      end else begin
        if (pick < 33) begin
          delta = $urandom_range(iv - 1);
        end else begin
          k     = ($urandom_range(99) < 85) ? $urandom_range(3, 1) : $urandom_range(5000, 4);
          delta = k * iv + $urandom_range(iv - 1);
        end
        push_command(lcc_pkg::CmdUpdate, gen_last + delta);
      end
    end
  endtask

  // Reset, directed cases, then random phases under different idling.
  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Empty strip at reset settings: every command gives a dark frame.
    push_command(lcc_pkg::CmdBegin, 32'd0);
    push_command(lcc_pkg::CmdUpdate, 32'd5);
    push_command(lcc_pkg::CmdUpdate, 32'hFFFF_FFFF);
    settle();

    // Three LEDs, zero interval acting as one, time wrapping past the top.
    set_all(8'd255, 8'd0, 8'd128, lcc_pkg::FacFull, 9'd0, 32'd0, 1'b0, 11'd3);
    push_command(lcc_pkg::CmdBegin, 32'hFFFF_FFFF);
    push_command(lcc_pkg::CmdUpdate, 32'hFFFF_FFFF);
    push_command(lcc_pkg::CmdUpdate, 32'd0);
    push_command(lcc_pkg::CmdUpdate, 32'd5);
    settle();

    // Single LED, largest interval, factors above full scale.
    set_all(8'd255, 8'd255, 8'd255, 9'd511, 9'd300, 32'hFFFF_FFFF, 1'b1, 11'd1);
    push_command(lcc_pkg::CmdBegin, 32'd100);
    push_command(lcc_pkg::CmdUpdate, 32'd99);
    push_command(lcc_pkg::CmdUpdate, 32'd200);
    settle();

    // Two LEDs, so no far tail; too-early tick before the first step.
    set_all(8'd1, 8'd128, 8'd254, 9'd0, 9'd1, 32'd7, 1'b1, 11'd2);
    push_command(lcc_pkg::CmdBegin, 32'd0);
    push_command(lcc_pkg::CmdUpdate, 32'd6);
    push_command(lcc_pkg::CmdUpdate, 32'd7);
    push_command(lcc_pkg::CmdUpdate, 32'd30);
    settle();

    // Length beyond the largest ring saturates; long elapsed times.
    set_all(8'd0, 8'd0, 8'd0, lcc_pkg::FacFull, lcc_pkg::FacFull, 32'd1, 1'b0, 11'd2047);
    push_command(lcc_pkg::CmdBegin, 32'h8000_0000);
    push_command(lcc_pkg::CmdUpdate, 32'h8000_03FF);
    push_command(lcc_pkg::CmdUpdate, 32'h801E_8480);
    push_command(lcc_pkg::CmdUpdate, 32'h7FFF_FFFF);
    settle();

    // Full ring moving downward.
    set_all(8'd200, 8'd100, 8'd50, 9'd129, 9'd255, 32'd1, 1'b1, 11'd1024);
    push_command(lcc_pkg::CmdBegin, 32'd0);
    push_command(lcc_pkg::CmdUpdate, 32'd1);
    push_command(lcc_pkg::CmdUpdate, 32'd3000);
    settle();

    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin sender_idle_pct = 46; recv_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  recv_stall_pct = 46; end
        default: begin sender_idle_pct = 35; recv_stall_pct = 35; end
      endcase
      random_setup();
      if (p == 2)
        stalls_asked++;
      queue_commands(PhaseItems);
      // Once, the sender stops mid-phase until the block has drained.
      if (p == 1) begin
        while (pending.size() > PhaseItems / 2) @(posedge clk);
        hold_sender = 1'b1;
        while (in_valid || frames_due.size() != 0) @(posedge clk);
        hold_sender = 1'b0;
      end
      settle();
    end

    if (mismatches == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
